/* design/sed_pkg.sv */
// Shared types, character codes and helper functions for the string escape decoder.
`default_nettype none

package sed_pkg;

  // Decoder mode, one-hot
  typedef enum logic [6:0] {
    MODE_PLAIN  = 7'b0000001,
    MODE_ESC    = 7'b0000010,
    MODE_OCT    = 7'b0000100,
    MODE_HEX0   = 7'b0001000,
    MODE_HEX1   = 7'b0010000,
    MODE_HEX2A  = 7'b0100000,
    MODE_HEX2B  = 7'b1000000
  } mode_t;

  // Most results one request can produce
  localparam int unsigned MaxRes = 3;
  localparam int unsigned CntW   = $clog2(MaxRes + 1);

  // Character codes
  localparam logic [7:0] CH_BSL = 8'h5C;  // backslash
  localparam logic [7:0] CH_X   = 8'h78;  // 'x'
  localparam logic [7:0] CH_A   = 8'h61;
  localparam logic [7:0] CH_B   = 8'h62;
  localparam logic [7:0] CH_F   = 8'h66;
  localparam logic [7:0] CH_N   = 8'h6E;
  localparam logic [7:0] CH_R   = 8'h72;
  localparam logic [7:0] CH_T   = 8'h74;
  localparam logic [7:0] CH_V   = 8'h76;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_LA  = 8'h61;
  localparam logic [7:0] CH_UA  = 8'h41;

  // Control codes the letter escapes map to
  localparam logic [7:0] CC_BEL = 8'd7;
  localparam logic [7:0] CC_BS  = 8'd8;
  localparam logic [7:0] CC_FF  = 8'd12;
  localparam logic [7:0] CC_LF  = 8'd10;
  localparam logic [7:0] CC_CR  = 8'd13;
  localparam logic [7:0] CC_HT  = 8'd9;
  localparam logic [7:0] CC_VT  = 8'd11;

  // Up to three result bytes gathered for one request
  typedef struct packed {
    logic [MaxRes-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
  } res_list_t;

  localparam res_list_t RES_EMPTY = '0;

  function automatic logic is_oct(input logic [7:0] c);
    return (c inside {[8'h30:8'h37]});
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      d = c - CH_0;
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - CH_LA + 8'd10;
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - CH_UA + 8'd10;
    end
    return d[3:0];
  endfunction

  // Append one byte; anything beyond the last slot is dropped
  function automatic res_list_t push(input res_list_t l, input logic [7:0] b);
    res_list_t r;
    r = l;
    if (l.cnt < CntW'(MaxRes)) begin
      r.bytes[l.cnt[1:0]] = b;
      r.cnt = l.cnt + 1'b1;
    end
    return r;
  endfunction

  // Octal value: above 255 gives (v>>4) first, then the low byte
  function automatic res_list_t push_octal(input res_list_t l, input logic [8:0] v);
    res_list_t r;
    r = l;
    if (v[8]) begin
      r = push(r, {3'b000, v[8:4]});
    end
    r = push(r, v[7:0]);
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/string_escape_decoder_core.sv */
// String literal body escape decoder: decode logic and result buffer.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+-------------------------
//  in      | in_valid, in_ready, in_byte, end_of_string | raw literal bytes
//  out     | out_valid, out_ready, out_byte, last_of_string | decoded bytes
//
// A request is decoded in the cycle it is taken; its 0 to 3 result bytes land
// in a three-entry result buffer, which drains one byte per cycle.
// One-byte requests flow at one per cycle while out is ready; one giving
// more holds in_ready low until the buffer is down to its last entry.
// Reset (rst, synchronous) empties the buffer and returns to plain mode.
// A stall on out holds the buffer and, once it has any entry, in.
`default_nettype none

module string_escape_decoder_core (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       end_of_string,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            last_of_string
);
  import sed_pkg::*;

  // Decoder state
  mode_t       mode;
  mode_t       mode_next;
  logic [8:0]  octal_value;
  logic [8:0]  octal_value_next;
  logic [1:0]  octal_digits_seen;
  logic [1:0]  octal_digits_seen_next;
  logic [7:0]  held_hex_char;
  logic [7:0]  held_hex_char_next;

  // Result buffer, entry 0 at the head
  logic [MaxRes-1:0][7:0] q_byte;
  logic [MaxRes-1:0]      q_last;
  logic [CntW-1:0]        q_cnt;

  res_list_t         res;
  logic [MaxRes-1:0] res_last;
  logic              accept;
  logic              pop;

  // Decode one byte
  always_comb begin
    logic [7:0] c;
    logic       do_plain;
    logic [8:0] ov;
    logic [1:0] od;
    c                      = in_byte;
    do_plain               = 1'b0;
    ov                     = {octal_value[5:0], c[2:0]};
    od                     = octal_digits_seen + 2'd1;
    res                    = RES_EMPTY;
    mode_next              = mode;
    octal_value_next       = octal_value;
    octal_digits_seen_next = octal_digits_seen;
    held_hex_char_next     = held_hex_char;

    case (mode)
      MODE_ESC: begin
        mode_next = MODE_PLAIN;
        if (is_oct(c)) begin
          octal_value_next       = {6'b0, c[2:0]};
          octal_digits_seen_next = 2'd1;
          mode_next              = MODE_OCT;
        end else begin
          case (c)
            CH_A:    res = push(res, CC_BEL);
            CH_B:    res = push(res, CC_BS);
            CH_F:    res = push(res, CC_FF);
            CH_N:    res = push(res, CC_LF);
            CH_R:    res = push(res, CC_CR);
            CH_T:    res = push(res, CC_HT);
            CH_V:    res = push(res, CC_VT);
            CH_X:    mode_next = MODE_HEX0;
            default: res = push(res, c);
          endcase
        end
      end
      MODE_OCT: begin
        if (is_oct(c) && octal_digits_seen != 2'd3) begin
          octal_value_next = ov;
          if (od == 2'd3) begin
            res                    = push_octal(res, ov);
            mode_next              = MODE_PLAIN;
            octal_digits_seen_next = 2'd0;
          end else begin
            octal_digits_seen_next = od;
          end
        end else begin
          res                    = push_octal(res, octal_value);
          octal_digits_seen_next = 2'd0;
          do_plain               = 1'b1;
        end
      end
      MODE_HEX0: begin
        if (is_hex(c)) begin
          held_hex_char_next = c;
          mode_next          = MODE_HEX1;
        end else begin
          res      = push(res, CH_X);
          do_plain = 1'b1;
        end
      end
      MODE_HEX1: begin
        if (is_hex(c)) begin
          res       = push(res, {hex_val(held_hex_char), hex_val(c)});
          mode_next = MODE_HEX2A;
        end else begin
          res      = push(res, CH_X);
          res      = push(res, held_hex_char);
          do_plain = 1'b1;
        end
      end
      MODE_HEX2A: begin
        if (is_hex(c)) begin
          held_hex_char_next = c;
          mode_next          = MODE_HEX2B;
        end else begin
          do_plain = 1'b1;
        end
      end
      MODE_HEX2B: begin
        if (is_hex(c)) begin
          res       = push(res, {hex_val(held_hex_char), hex_val(c)});
          mode_next = MODE_PLAIN;
        end else begin
          res      = push(res, held_hex_char);
          do_plain = 1'b1;
        end
      end
      default: do_plain = 1'b1;
    endcase

    // Byte taken as plain text
    if (do_plain) begin
      if (c == CH_BSL) begin
        mode_next = MODE_ESC;
      end else begin
        mode_next = MODE_PLAIN;
        res       = push(res, c);
      end
    end

    // End of string: flush whatever is still open
    if (end_of_string) begin
      case (mode_next)
        MODE_ESC:   res = push(res, CH_BSL);
        MODE_OCT:   res = push_octal(res, octal_value_next);
        MODE_HEX0:  res = push(res, CH_X);
        MODE_HEX1: begin
          res = push(res, CH_X);
          res = push(res, held_hex_char_next);
        end
        MODE_HEX2B: res = push(res, held_hex_char_next);
        default:    ;
      endcase
      mode_next              = MODE_PLAIN;
      octal_digits_seen_next = 2'd0;
    end

    // Mark the final byte of the string
    res_last = '0;
    if (end_of_string && res.cnt != '0) begin
      res_last[2'(res.cnt - 1'b1)] = 1'b1;
    end
  end

  // Handshakes
  assign out_valid      = (q_cnt != '0);
  assign pop            = out_valid && out_ready;
  assign in_ready       = (q_cnt == '0) || (q_cnt == CntW'(1) && out_ready);
  assign accept         = in_valid && in_ready;
  assign out_byte       = q_byte[0];
  assign last_of_string = q_last[0];

  // Decoder state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_PLAIN;
      octal_value       <= '0;
      octal_digits_seen <= '0;
      held_hex_char     <= '0;
    end else if (accept) begin
      mode              <= mode_next;
      octal_value       <= octal_value_next;
      octal_digits_seen <= octal_digits_seen_next;
      held_hex_char     <= held_hex_char_next;
    end
  end

  // Result buffer count
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= '0;
    end else if (accept) begin
      q_cnt <= res.cnt;
    end else if (pop) begin
      q_cnt <= q_cnt - 1'b1;
    end
  end

  // Result buffer payload: load on a request, shift on a take
  always_ff @(posedge clk) begin
    if (accept) begin
      q_byte <= res.bytes;
      q_last <= res_last;
    end else if (pop) begin
      q_byte <= {8'h00, q_byte[MaxRes-1:1]};
      q_last <= {1'b0, q_last[MaxRes-1:1]};
    end
  end

  // End of string always leaves the decoder in plain mode
  a_eos_plain: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_string |=> mode == MODE_PLAIN)
    else $error("decoder not in plain mode after end of string");

  // The final byte of a string is always the last one buffered
  a_last_tail: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_string |-> q_cnt == CntW'(1))
    else $error("last byte of string not at buffer tail");

  // A request fills the buffer with exactly its results
  a_load_cnt: assert property (@(posedge clk) disable iff (rst)
    accept |=> q_cnt == $past(res.cnt))
    else $error("buffer count mismatch after request");

  // A take without a request removes exactly one entry
  a_pop_cnt: assert property (@(posedge clk) disable iff (rst)
    pop && !accept |=> q_cnt == $past(q_cnt) - 1'b1)
    else $error("buffer count mismatch after take");

endmodule

`default_nettype wire

/* test/string_escape_decoder_core_test.sv */
// Self-checking testbench for the string escape decoder core: directed table, then random strings.
module string_escape_decoder_core_test;
  import sed_pkg::*;

  localparam int unsigned RunLimit  = 2_000_000;
  localparam int unsigned RandItems = 400;

  // Digit bounds the decode rules need beyond the package codes
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  localparam logic [7:0] LETTERS [7] = '{CH_A, CH_B, CH_F, CH_N, CH_R, CH_T, CH_V};

  // One request; typed rows carry their own expected bytes
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       typed;
    logic [1:0] count;
    logic [7:0] e0;
    logic [7:0] e1;
    logic [7:0] e2;
  } row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } awaited_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       end_of_string = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_string;
  row_t       row_info = '0;

  int unsigned fail_count = 0;
  awaited_t    awaited_bytes[$];
  row_t        random_rows[$];

  // Decoder state as predicted
  mode_t      dec_mode = MODE_PLAIN;
  logic [8:0] oct_acc = '0;
  logic [1:0] oct_count = '0;
  logic [7:0] hex_held = '0;
  logic [7:0] fresh[$];   // bytes from the request being decoded

  // Directed requests: extremes, every letter escape, octal overflow, broken \x, lone backslash
  localparam int unsigned NumDirected = 26;
  localparam row_t DIRECTED [NumDirected] = '{
    '{CH_BSL, 1'b0, 1'b1, 2'd0, 8'h00,  8'h00, 8'h00},
    '{8'hFF,  1'b0, 1'b1, 2'd1, 8'hFF,  8'h00, 8'h00},
    '{CH_BSL, 1'b0, 1'b1, 2'd0, 8'h00,  8'h00, 8'h00},
    '{CH_A,   1'b0, 1'b1, 2'd1, CC_BEL, 8'h00, 8'h00},
    '{CH_BSL, 1'b0, 1'b1, 2'd0, 8'h00,  8'h00, 8'h00},
    '{CH_B,   1'b0, 1'b1, 2'd1, CC_BS,  8'h00, 8'h00},
    '{CH_BSL, 1'b0, 1'b1, 2'd0, 8'h00,  8'h00, 8'h00},
    '{CH_F,   1'b0, 1'b1, 2'd1, CC_FF,  8'h00, 8'h00},
    '{CH_BSL, 1'b0, 1'b1, 2'd0, 8'h00,  8'h00, 8'h00},
    '{CH_N,   1'b0, 1'b1, 2'd1, CC_LF,  8'h00, 8'h00},
    '{CH_BSL, 1'b0, 1'b1, 2'd0, 8'h00,  8'h00, 8'h00},
    '{CH_R,   1'b0, 1'b1, 2'd1, CC_CR,  8'h00, 8'h00},
    '{CH_BSL, 1'b0, 1'b1, 2'd0, 8'h00,  8'h00, 8'h00},
    '{CH_T,   1'b0, 1'b1, 2'd1, CC_HT,  8'h00, 8'h00},
    '{CH_BSL, 1'b0, 1'b1, 2'd0, 8'h00,  8'h00, 8'h00},
    '{CH_V,   1'b0, 1'b1, 2'd1, CC_VT,  8'h00, 8'h00},
    // \777 is 511, too large for one byte
    '{CH_BSL, 1'b0, 1'b0, 2'd0, 8'h00,  8'h00, 8'h00},
    '{CH_7,   1'b0, 1'b0, 2'd0, 8'h00,  8'h00, 8'h00},
    '{CH_7,   1'b0, 1'b0, 2'd0, 8'h00,  8'h00, 8'h00},
    '{CH_7,   1'b0, 1'b0, 2'd0, 8'h00,  8'h00, 8'h00},
    // \x4 broken by a non-hex byte that also ends the string
    '{CH_BSL, 1'b0, 1'b0, 2'd0, 8'h00,  8'h00, 8'h00},
    '{CH_X,   1'b0, 1'b0, 2'd0, 8'h00,  8'h00, 8'h00},
    '{8'h34,  1'b0, 1'b0, 2'd0, 8'h00,  8'h00, 8'h00},
    '{8'h67,  1'b1, 1'b0, 2'd0, 8'h00,  8'h00, 8'h00},
    '{8'h00,  1'b0, 1'b1, 2'd1, 8'h00,  8'h00, 8'h00},
    // lone backslash at the end is kept
    '{CH_BSL, 1'b1, 1'b1, 2'd1, CH_BSL, 8'h00, 8'h00}
  };

  string_escape_decoder_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .end_of_string  (end_of_string),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .last_of_string (last_of_string)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- prediction

  function automatic logic octal_digit(input logic [7:0] c);
    return c >= CH_0 && c <= CH_7;
  endfunction

  function automatic logic hex_digit(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LOW_F) ||
           (c >= CH_UA && c <= CH_UP_F);
  endfunction

  // only called on hex digits
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c <= CH_9) return 4'(c - CH_0);
    if (c >= CH_LA) return 4'(c - CH_LA + 8'd10);
    return 4'(c - CH_UA + 8'd10);
  endfunction

  function automatic void put(input logic [7:0] b);
    if (fresh.size() < MaxRes) fresh.push_back(b);
  endfunction

  // values above 255 give the upper bits first
  function automatic void put_octal();
    if (oct_acc > 9'd255) put(8'(oct_acc >> 4));
    put(oct_acc[7:0]);
  endfunction

  function automatic void take_plain(input logic [7:0] c);
    if (c == CH_BSL) begin
      dec_mode = MODE_ESC;
    end else begin
      dec_mode = MODE_PLAIN;
      put(c);
    end
  endfunction

  function automatic void take_escaped(input logic [7:0] c);
    dec_mode = MODE_PLAIN;
    if (octal_digit(c)) begin
      oct_acc   = 9'(c - CH_0);
      oct_count = 2'd1;
      dec_mode  = MODE_OCT;
    end else begin
      case (c)
        CH_A: put(CC_BEL);
        CH_B: put(CC_BS);
        CH_F: put(CC_FF);
        CH_N: put(CC_LF);
        CH_R: put(CC_CR);
        CH_T: put(CC_HT);
        CH_V: put(CC_VT);
        CH_X: dec_mode = MODE_HEX0;
        default: put(c);
      endcase
    end
  endfunction

  // Bytes one request produces, with the flush at end of string
  function automatic void decode_request(input logic [7:0] c, input logic eos);
    fresh.delete();
    case (dec_mode)
      MODE_ESC: take_escaped(c);
      MODE_OCT: begin
        if (octal_digit(c) && oct_count < 2'd3) begin
          oct_acc   = {oct_acc[5:0], 3'(c - CH_0)};
          oct_count = oct_count + 2'd1;
          if (oct_count == 2'd3) begin
            put_octal();
            dec_mode  = MODE_PLAIN;
            oct_count = 2'd0;
          end
        end else begin
          put_octal();
          oct_count = 2'd0;
          take_plain(c);
        end
      end
      MODE_HEX0: begin
        if (hex_digit(c)) begin
          hex_held = c;
          dec_mode = MODE_HEX1;
        end else begin
          put(CH_X);
          take_plain(c);
        end
      end
      MODE_HEX1: begin
        if (hex_digit(c)) begin
          put({hex_nibble(hex_held), hex_nibble(c)});
          dec_mode = MODE_HEX2A;
        end else begin
          put(CH_X);
          put(hex_held);
          take_plain(c);
        end
      end
      MODE_HEX2A: begin
        if (hex_digit(c)) begin
          hex_held = c;
          dec_mode = MODE_HEX2B;
        end else begin
          take_plain(c);
        end
      end
      MODE_HEX2B: begin
        if (hex_digit(c)) begin
          put({hex_nibble(hex_held), hex_nibble(c)});
          dec_mode = MODE_PLAIN;
        end else begin
          put(hex_held);
          take_plain(c);
        end
      end
      default: take_plain(c);
    endcase
    if (eos) begin
      case (dec_mode)
        MODE_ESC: put(CH_BSL);
        MODE_OCT: put_octal();
        MODE_HEX0: put(CH_X);
        MODE_HEX1: begin
          put(CH_X);
          put(hex_held);
        end
        MODE_HEX2B: put(hex_held);
        default: ;
      endcase
      dec_mode  = MODE_PLAIN;
      oct_count = 2'd0;
    end
  endfunction

  // Predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    awaited_t want;
    if (rst) begin
      dec_mode  = MODE_PLAIN;
      oct_acc   = '0;
      oct_count = '0;
      hex_held  = '0;
    end else begin
      if (in_valid && in_ready) begin
        decode_request(in_byte, end_of_string);
        if (row_info.typed) begin
          fresh.delete();
          if (row_info.count > 2'd0) fresh.push_back(row_info.e0);
          if (row_info.count > 2'd1) fresh.push_back(row_info.e1);
          if (row_info.count > 2'd2) fresh.push_back(row_info.e2);
        end
        foreach (fresh[i])
          awaited_bytes.push_back({fresh[i], end_of_string && i == fresh.size() - 1});
      end
      if (out_valid && out_ready) begin
        if (awaited_bytes.size() == 0) begin
          $error("out_byte %02h arrived with nothing outstanding", out_byte);
          fail_count++;
        end else begin
          want = awaited_bytes.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, got %02h", want.data, out_byte);
            fail_count++;
          end
          if (last_of_string !== want.last) begin
            $error("last_of_string: expected %0b, got %0b", want.last, last_of_string);
            fail_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // mostly short, now and then long
  function automatic int unsigned idle_span();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // every third block of fifty requests runs back to back
  function automatic int unsigned sender_idle(input int unsigned idx);
    if ((idx / 50) % 3 == 0) return 0;
    if ($urandom_range(0, 1) == 0) return 0;
    return idle_span();
  endfunction

  function automatic row_t make_row(input logic [7:0] b, input logic eos);
    row_t r;
    r      = '0;
    r.data = b;
    r.eos  = eos;
    return r;
  endfunction

  function automatic logic [7:0] any_hex_digit();
    int unsigned k;
    k = $urandom_range(0, 21);
    if (k < 10) return CH_0 + 8'(k);
    if (k < 16) return CH_LA + 8'(k - 10);
    return CH_UA + 8'(k - 16);
  endfunction

  // One string: mostly well-formed escapes with random content, some raw noise
  function automatic void add_random_string();
    logic [7:0] body[$];
    logic [7:0] b;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 6))
        random_rows.push_back(make_row(8'($urandom), $urandom_range(0, 3) == 0));
    end else begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 5))
          0: begin
            do b = 8'($urandom); while (b == CH_BSL);
            body.push_back(b);
          end
          1: begin
            body.push_back(CH_BSL);
            body.push_back(LETTERS[$urandom_range(0, 6)]);
          end
          2: begin
            body.push_back(CH_BSL);
            body.push_back(8'($urandom));
          end
          3: begin
            body.push_back(CH_BSL);
            repeat ($urandom_range(1, 3)) body.push_back(CH_0 + 8'($urandom_range(0, 7)));
          end
          default: begin
            body.push_back(CH_BSL);
            body.push_back(CH_X);
            repeat ($urandom_range(0, 4)) body.push_back(any_hex_digit());
          end
        endcase
      end
      if ($urandom_range(0, 9) == 0) body.push_back(CH_BSL);
      foreach (body[i]) random_rows.push_back(make_row(body[i], i == body.size() - 1));
    end
  endfunction

  // Offer one request and hold it until taken
  task automatic send_request(input row_t r, input int unsigned idle);
    if (idle != 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_byte       <= r.data;
    end_of_string <= r.eos;
    row_info      <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender holds off until every outstanding byte has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_bytes.size() != 0);
  endtask

  // Receiver stalls at random, but starts no new stall in one stretch out of three
  int unsigned stall_left = 0;
  int unsigned rx_cycle = 0;
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ((rx_cycle / 120) % 3 != 1 && $urandom_range(0, 3) == 0) begin
      stall_left <= idle_span() - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) send_request(DIRECTED[i], sender_idle(i));
    drain();
    while (random_rows.size() < RandItems) add_random_string();
    foreach (random_rows[i]) begin
      if (i == random_rows.size() / 2) drain();
      send_request(random_rows[i], sender_idle(i));
    end
    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog
  initial begin
    #(RunLimit);
    $display("tb: failure");
    $finish;
  end

endmodule

/* sim.f */
design/sed_pkg.sv
design/string_escape_decoder_core.sv
test/string_escape_decoder_core_test.sv
